>>> design/pcm_pkg.sv
`timescale 1ns / 1ps

package pcm_pkg;

    localparam int CFG_IDX_W = 3;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_WINDOW_SAMPLES = 3'd0;
    localparam t_cfg_idx CFG_NOISE_FLOOR    = 3'd1;
    localparam t_cfg_idx CFG_MIN_HITS       = 3'd2;
    localparam t_cfg_idx CFG_GAIN_Q16       = 3'd3;
    localparam t_cfg_idx CFG_OFFSET_MA      = 3'd4;
    localparam t_cfg_idx CFG_ZERO_FLOOR_MA  = 3'd5;
    localparam t_cfg_idx CFG_LINE_VOLTS     = 3'd6;

    localparam int SAMPLE_W  = 12;
    localparam int WIN_W     = 10;
    localparam int FLOOR_W   = 12;
    localparam int HITS_W    = 10;
    localparam int GAIN_W    = 24;
    localparam int MA_W      = 16;
    localparam int VOLTS_W   = 9;
    localparam int CURRENT_W = 18;
    localparam int POWER_W   = 27;
    localparam int CFG_DATA_W = 24;

    localparam logic [WIN_W-1:0]   RST_WINDOW_SAMPLES = 10'd35;
    localparam logic [FLOOR_W-1:0] RST_NOISE_FLOOR    = 12'd4;
    localparam logic [HITS_W-1:0]  RST_MIN_HITS       = 10'd3;
    localparam logic [GAIN_W-1:0]  RST_GAIN_Q16       = 24'd2712152;
    localparam logic [MA_W-1:0]    RST_OFFSET_MA      = 16'd140;
    localparam logic [MA_W-1:0]    RST_ZERO_FLOOR_MA  = 16'd200;
    localparam logic [VOLTS_W-1:0] RST_LINE_VOLTS     = 9'd120;

    localparam logic [CURRENT_W-1:0] CURRENT_MAX = 18'd262143;
    localparam logic [POWER_W-1:0]   POWER_MAX   = 27'd134217727;

    localparam int GAIN_FRAC = 16;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL1 = 5'b00010,
        S_FILT = 5'b00100,
        S_MUL2 = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

endpackage

>>> design/pcm_mul.sv
`timescale 1ns / 1ps

module pcm_mul #(
    parameter int A_W = 24,
    parameter int B_W = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [A_W-1:0]     i_a,
    input  logic [B_W-1:0]     i_b,
    output logic               o_done,
    output logic [A_W+B_W-1:0] o_prod
);

    localparam int P_W   = A_W + B_W;
    localparam int CNT_W = $clog2(B_W + 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [P_W-1:0]   r_acc, n_acc;
    logic [P_W-1:0]   r_a, n_a;
    logic [B_W-1:0]   r_b, n_b;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_a    = r_a;
        n_b    = r_b;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_acc  = '0;
            n_a    = P_W'(i_a);
            n_b    = i_b;
        end else if (r_busy) begin
            if (r_b[0]) begin
                n_acc = r_acc + r_a;
            end
            n_a   = r_a << 1;
            n_b   = r_b >> 1;
            n_cnt = r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(B_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

>>> design/peak_current_meter_ema.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake                  Payload
// in       input      i_in_valid / o_in_stall    i_sample
// out      output     o_out_valid / i_out_stall  o_current_ma, o_power_mw, o_signal_seen
// cfg      input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// A mid-window sample is taken without a stall; a sample that closes a window
// stalls the input through S_MUL1, S_FILT, S_MUL2 and S_DONE, as the bit-serial
// shift-add multiplier is used twice, for the gain and for the power.
// Reset is synchronous, active low, and restores register defaults.
// A finished result waits in the output register while new samples are taken;
// a window end waits only while that register is still full and stalled.

module peak_current_meter_ema #(
    parameter int ADC_BITS   = 12,
    parameter int COUNT_BITS = 10
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [pcm_pkg::SAMPLE_W-1:0]       i_sample,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [pcm_pkg::CURRENT_W-1:0]      o_current_ma,
    output logic [pcm_pkg::POWER_W-1:0]        o_power_mw,
    output logic                               o_signal_seen,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  pcm_pkg::t_cfg_idx                  i_cfg_index,
    input  logic [pcm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int MB_W  = (ADC_BITS > pcm_pkg::VOLTS_W) ? ADC_BITS : pcm_pkg::VOLTS_W;
    localparam int P_W   = pcm_pkg::GAIN_W + MB_W;
    localparam int HI_W  = P_W - pcm_pkg::GAIN_FRAC;
    localparam int RAW_W = HI_W + 1;
    localparam int NX_W  = COUNT_BITS + 1;
    localparam int WC_W  = (NX_W > pcm_pkg::WIN_W) ? NX_W : pcm_pkg::WIN_W;
    localparam int FC_W  = (ADC_BITS > pcm_pkg::FLOOR_W) ? ADC_BITS : pcm_pkg::FLOOR_W;
    localparam int HC_W  = (COUNT_BITS > pcm_pkg::HITS_W) ? COUNT_BITS : pcm_pkg::HITS_W;
    localparam int SUM_W = pcm_pkg::CURRENT_W + 2;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [pcm_pkg::WIN_W-1:0]   r_window_samples;
    logic [pcm_pkg::FLOOR_W-1:0] r_noise_floor;
    logic [pcm_pkg::HITS_W-1:0]  r_min_hits;
    logic [pcm_pkg::GAIN_W-1:0]  r_gain_q16;
    logic [pcm_pkg::MA_W-1:0]    r_offset_ma;
    logic [pcm_pkg::MA_W-1:0]    r_zero_floor_ma;
    logic [pcm_pkg::VOLTS_W-1:0] r_line_volts;

    pcm_pkg::t_state r_state, n_state;

    logic [ADC_BITS-1:0]            r_peak, n_peak;
    logic [COUNT_BITS-1:0]          r_hits, n_hits;
    logic [COUNT_BITS-1:0]          r_idx, n_idx;
    logic [pcm_pkg::CURRENT_W-1:0]  r_filt, n_filt;
    logic [pcm_pkg::CURRENT_W-1:0]  r_raw, n_raw;
    logic                           r_qual, n_qual;
    logic [pcm_pkg::POWER_W-1:0]    r_pwr, n_pwr;
    logic                           r_out_valid, n_out_valid;
    logic [pcm_pkg::CURRENT_W-1:0]  r_current, n_current;
    logic [pcm_pkg::POWER_W-1:0]    r_power, n_power;
    logic                           r_seen, n_seen;

    logic                          w_in_acc;
    logic [ADC_BITS-1:0]           w_s;
    logic [ADC_BITS-1:0]           w_peak;
    logic [COUNT_BITS-1:0]         w_hits;
    logic [NX_W-1:0]               w_next;
    logic [pcm_pkg::WIN_W-1:0]     w_win;
    logic                          w_end;
    logic                          w_qual;
    logic                          w_mul_start;
    logic [pcm_pkg::GAIN_W-1:0]    w_mul_a;
    logic [MB_W-1:0]               w_mul_b;
    logic                          w_mul_done;
    logic [P_W-1:0]                w_prod;
    logic [RAW_W-1:0]              w_raw_sum;
    logic [SUM_W-1:0]              w_avg_sum;
    logic [pcm_pkg::CURRENT_W-1:0] w_avg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_samples <= pcm_pkg::RST_WINDOW_SAMPLES;
            r_noise_floor    <= pcm_pkg::RST_NOISE_FLOOR;
            r_min_hits       <= pcm_pkg::RST_MIN_HITS;
            r_gain_q16       <= pcm_pkg::RST_GAIN_Q16;
            r_offset_ma      <= pcm_pkg::RST_OFFSET_MA;
            r_zero_floor_ma  <= pcm_pkg::RST_ZERO_FLOOR_MA;
            r_line_volts     <= pcm_pkg::RST_LINE_VOLTS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pcm_pkg::CFG_WINDOW_SAMPLES: r_window_samples <= i_cfg_data[pcm_pkg::WIN_W-1:0];
                pcm_pkg::CFG_NOISE_FLOOR:    r_noise_floor    <= i_cfg_data[pcm_pkg::FLOOR_W-1:0];
                pcm_pkg::CFG_MIN_HITS:       r_min_hits       <= i_cfg_data[pcm_pkg::HITS_W-1:0];
                pcm_pkg::CFG_GAIN_Q16:       r_gain_q16       <= i_cfg_data[pcm_pkg::GAIN_W-1:0];
                pcm_pkg::CFG_OFFSET_MA:      r_offset_ma      <= i_cfg_data[pcm_pkg::MA_W-1:0];
                pcm_pkg::CFG_ZERO_FLOOR_MA:  r_zero_floor_ma  <= i_cfg_data[pcm_pkg::MA_W-1:0];
                pcm_pkg::CFG_LINE_VOLTS:     r_line_volts     <= i_cfg_data[pcm_pkg::VOLTS_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_in_stall = (r_state != pcm_pkg::S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;

    assign w_s    = ADC_BITS'(i_sample);
    assign w_peak = (w_s > r_peak) ? w_s : r_peak;
    assign w_hits = ((FC_W'(w_s) >= FC_W'(r_noise_floor)) && (r_hits != COUNT_MAX))
                    ? r_hits + COUNT_BITS'(1) : r_hits;
    assign w_next = NX_W'(r_idx) + NX_W'(1);
    assign w_win  = (r_window_samples == '0) ? pcm_pkg::WIN_W'(1) : r_window_samples;
    assign w_end  = !((WC_W'(w_next) < WC_W'(w_win)) && (w_next < NX_W'(COUNT_MAX)));
    assign w_qual = (FC_W'(w_peak) >= FC_W'(r_noise_floor))
                    && (HC_W'(w_hits) > HC_W'(r_min_hits));

    assign w_raw_sum = RAW_W'(w_prod[P_W-1:pcm_pkg::GAIN_FRAC]) + RAW_W'(r_offset_ma);
    assign w_avg_sum = SUM_W'(r_raw) + (SUM_W'(r_filt) << 1) + SUM_W'(r_filt);
    assign w_avg     = w_avg_sum[SUM_W-1:2];

    assign w_mul_start = (w_in_acc && w_end) || (r_state == pcm_pkg::S_FILT);
    assign w_mul_a     = (r_state == pcm_pkg::S_FILT) ? pcm_pkg::GAIN_W'(n_filt) : r_gain_q16;
    assign w_mul_b     = (r_state == pcm_pkg::S_FILT) ? MB_W'(r_line_volts) : MB_W'(w_peak);

    pcm_mul #(
        .A_W (pcm_pkg::GAIN_W),
        .B_W (MB_W)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    always_comb begin
        n_state     = r_state;
        n_peak      = r_peak;
        n_hits      = r_hits;
        n_idx       = r_idx;
        n_filt      = r_filt;
        n_raw       = r_raw;
        n_qual      = r_qual;
        n_pwr       = r_pwr;
        n_out_valid = r_out_valid && i_out_stall;
        n_current   = r_current;
        n_power     = r_power;
        n_seen      = r_seen;
        case (r_state)
            pcm_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    if (w_end) begin
                        n_peak  = '0;
                        n_hits  = '0;
                        n_idx   = '0;
                        n_qual  = w_qual;
                        n_state = pcm_pkg::S_MUL1;
                    end else begin
                        n_peak = w_peak;
                        n_hits = w_hits;
                        n_idx  = w_next[COUNT_BITS-1:0];
                    end
                end
            end
            pcm_pkg::S_MUL1: begin
                if (w_mul_done) begin
                    if (!r_qual) begin
                        n_raw = '0;
                    end else if (w_raw_sum > RAW_W'(pcm_pkg::CURRENT_MAX)) begin
                        n_raw = pcm_pkg::CURRENT_MAX;
                    end else begin
                        n_raw = w_raw_sum[pcm_pkg::CURRENT_W-1:0];
                    end
                    n_state = pcm_pkg::S_FILT;
                end
            end
            pcm_pkg::S_FILT: begin
                if (w_avg < pcm_pkg::CURRENT_W'(r_zero_floor_ma)) begin
                    n_filt = '0;
                end else begin
                    n_filt = w_avg;
                end
                n_state = pcm_pkg::S_MUL2;
            end
            pcm_pkg::S_MUL2: begin
                if (w_mul_done) begin
                    if (w_prod[P_W-1:pcm_pkg::POWER_W] != '0) begin
                        n_pwr = pcm_pkg::POWER_MAX;
                    end else begin
                        n_pwr = w_prod[pcm_pkg::POWER_W-1:0];
                    end
                    n_state = pcm_pkg::S_DONE;
                end
            end
            pcm_pkg::S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_current   = r_filt;
                    n_power     = r_pwr;
                    n_seen      = r_qual;
                    n_state     = pcm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pcm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pcm_pkg::S_IDLE;
            r_peak      <= '0;
            r_hits      <= '0;
            r_idx       <= '0;
            r_filt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_peak      <= n_peak;
            r_hits      <= n_hits;
            r_idx       <= n_idx;
            r_filt      <= n_filt;
            r_out_valid <= n_out_valid;
        end
        r_raw     <= n_raw;
        r_qual    <= n_qual;
        r_pwr     <= n_pwr;
        r_current <= n_current;
        r_power   <= n_power;
        r_seen    <= n_seen;
    end

    assign o_out_valid   = r_out_valid;
    assign o_current_ma  = r_current;
    assign o_power_mw    = r_power;
    assign o_signal_seen = r_seen;

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state register lost one-hot encoding");

    a_mul_done_in_mul_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> (r_state == pcm_pkg::S_MUL1 || r_state == pcm_pkg::S_MUL2))
        else $error("multiplier finished outside a multiply state");

    a_out_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == pcm_pkg::S_DONE))
        else $error("result loaded without finishing a window");

    a_idx_below_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx != COUNT_MAX)
        else $error("sample index reached counter limit");

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int IDLE_PCT      = 11;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 64;
    localparam int LIMIT_CYCLES  = 600000;
    localparam logic [pcm_pkg::WIN_W:0] COUNT_MAX = 11'd1023;
    localparam pcm_pkg::t_cfg_idx CFG_UNUSED = 3'd7;

    localparam logic [pcm_pkg::SAMPLE_W-1:0] EDGE_SAMPLES [14] = '{
        12'd0, 12'd99, 12'd100, 12'd101, 12'd4095, 12'd4095, 12'd1,
        12'd2048, 12'd4095, 12'd0, 12'd0, 12'd0, 12'd100, 12'd4094
    };
    localparam logic [pcm_pkg::SAMPLE_W-1:0] FLOOR_SAMPLES [6] = '{
        12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4094
    };

    typedef struct packed {
        logic [pcm_pkg::CURRENT_W-1:0] current_ma;
        logic [pcm_pkg::POWER_W-1:0]   power_mw;
        logic                          signal_seen;
    } t_reading;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                           in_valid = 1'b0;
    logic [pcm_pkg::SAMPLE_W-1:0]   in_sample = '0;
    logic                           out_stall = 1'b0;
    logic                           cfg_valid = 1'b0;
    pcm_pkg::t_cfg_idx              cfg_index = pcm_pkg::CFG_WINDOW_SAMPLES;
    logic [pcm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    logic                          o_in_stall;
    logic                          o_out_valid;
    logic [pcm_pkg::CURRENT_W-1:0] o_current_ma;
    logic [pcm_pkg::POWER_W-1:0]   o_power_mw;
    logic                          o_signal_seen;
    logic                          o_cfg_ready;

    logic [pcm_pkg::WIN_W-1:0]   cfg_window;
    logic [pcm_pkg::FLOOR_W-1:0] cfg_floor;
    logic [pcm_pkg::HITS_W-1:0]  cfg_min_hits;
    logic [pcm_pkg::GAIN_W-1:0]  cfg_gain;
    logic [pcm_pkg::MA_W-1:0]    cfg_offset;
    logic [pcm_pkg::MA_W-1:0]    cfg_zero_floor;
    logic [pcm_pkg::VOLTS_W-1:0] cfg_volts;

    logic [pcm_pkg::SAMPLE_W-1:0]  run_peak = '0;
    logic [pcm_pkg::WIN_W-1:0]     run_hits = '0;
    logic [pcm_pkg::WIN_W-1:0]     run_index = '0;
    logic [pcm_pkg::CURRENT_W-1:0] avg_ma = '0;

    logic [pcm_pkg::SAMPLE_W-1:0] sample_fifo [$];
    t_reading                     pending_readings [$];

    int  mismatches = 0;
    bit  calm = 1'b0;
    bit  hold_req = 1'b0;
    bit  hold_used = 1'b0;
    int  hold_left = 0;

    peak_current_meter_ema dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (o_in_stall),
        .i_sample      (in_sample),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (out_stall),
        .o_current_ma  (o_current_ma),
        .o_power_mw    (o_power_mw),
        .o_signal_seen (o_signal_seen),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic void load_defaults();
        cfg_window     = pcm_pkg::RST_WINDOW_SAMPLES;
        cfg_floor      = pcm_pkg::RST_NOISE_FLOOR;
        cfg_min_hits   = pcm_pkg::RST_MIN_HITS;
        cfg_gain       = pcm_pkg::RST_GAIN_Q16;
        cfg_offset     = pcm_pkg::RST_OFFSET_MA;
        cfg_zero_floor = pcm_pkg::RST_ZERO_FLOOR_MA;
        cfg_volts      = pcm_pkg::RST_LINE_VOLTS;
    endfunction

    function automatic void predict_reading(input logic [pcm_pkg::SAMPLE_W-1:0] s);
        logic [pcm_pkg::WIN_W:0] win;
        logic [pcm_pkg::WIN_W:0] nxt;
        logic                    qual;
        logic [63:0]             raw;
        logic [63:0]             filt;
        logic [63:0]             pwr;
        t_reading                r;
        win = (cfg_window == '0) ? 11'd1 : {1'b0, cfg_window};
        if (s > run_peak) run_peak = s;
        if (s >= cfg_floor && {1'b0, run_hits} < COUNT_MAX) run_hits = run_hits + 1'b1;
        nxt = {1'b0, run_index} + 11'd1;
        if (nxt < win && nxt < COUNT_MAX) begin
            run_index = nxt[pcm_pkg::WIN_W-1:0];
            return;
        end
        qual = (run_peak >= cfg_floor) && (run_hits > cfg_min_hits);
        raw = '0;
        if (qual) begin
            raw = ((64'(cfg_gain) * 64'(run_peak)) >> pcm_pkg::GAIN_FRAC) + 64'(cfg_offset);
            if (raw > 64'(pcm_pkg::CURRENT_MAX)) raw = 64'(pcm_pkg::CURRENT_MAX);
        end
        filt = (raw + 64'd3 * 64'(avg_ma)) >> 2;
        if (filt < 64'(cfg_zero_floor)) filt = '0;
        avg_ma = filt[pcm_pkg::CURRENT_W-1:0];
        pwr = filt * 64'(cfg_volts);
        if (pwr > 64'(pcm_pkg::POWER_MAX)) pwr = 64'(pcm_pkg::POWER_MAX);
        r.current_ma  = filt[pcm_pkg::CURRENT_W-1:0];
        r.power_mw    = pwr[pcm_pkg::POWER_W-1:0];
        r.signal_seen = qual;
        pending_readings.push_back(r);
        run_peak  = '0;
        run_hits  = '0;
        run_index = '0;
    endfunction

    function automatic logic [pcm_pkg::SAMPLE_W-1:0] draw_sample();
        int pick;
        int near;
        pick = int'($urandom_range(99));
        near = int'(cfg_floor) + int'($urandom_range(16)) - 8;
        if (pick < 30) return pcm_pkg::SAMPLE_W'($urandom);
        if (pick < 50) return (near < 0) ? '0 : (near > 4095) ? 12'd4095 : pcm_pkg::SAMPLE_W'(near);
        if (pick < 58) return '0;
        if (pick < 66) return 12'd4095;
        return pcm_pkg::SAMPLE_W'($urandom_range(400));
    endfunction

    task automatic write_reg(input pcm_pkg::t_cfg_idx idx,
                             input logic [pcm_pkg::CFG_DATA_W-1:0] value);
        int                             w;
        logic [pcm_pkg::CFG_DATA_W-1:0] mask;
        logic [pcm_pkg::CFG_DATA_W-1:0] data;
        case (idx)
            pcm_pkg::CFG_WINDOW_SAMPLES: w = pcm_pkg::WIN_W;
            pcm_pkg::CFG_NOISE_FLOOR:    w = pcm_pkg::FLOOR_W;
            pcm_pkg::CFG_MIN_HITS:       w = pcm_pkg::HITS_W;
            pcm_pkg::CFG_GAIN_Q16:       w = pcm_pkg::GAIN_W;
            pcm_pkg::CFG_OFFSET_MA:      w = pcm_pkg::MA_W;
            pcm_pkg::CFG_ZERO_FLOOR_MA:  w = pcm_pkg::MA_W;
            pcm_pkg::CFG_LINE_VOLTS:     w = pcm_pkg::VOLTS_W;
            default:                     w = 0;
        endcase
        mask = (w >= pcm_pkg::CFG_DATA_W) ? '1 : ((pcm_pkg::CFG_DATA_W'(1) << w) - 1'b1);
        data = (value & mask) | (pcm_pkg::CFG_DATA_W'($urandom) & ~mask);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            pcm_pkg::CFG_WINDOW_SAMPLES: cfg_window     = data[pcm_pkg::WIN_W-1:0];
            pcm_pkg::CFG_NOISE_FLOOR:    cfg_floor      = data[pcm_pkg::FLOOR_W-1:0];
            pcm_pkg::CFG_MIN_HITS:       cfg_min_hits   = data[pcm_pkg::HITS_W-1:0];
            pcm_pkg::CFG_GAIN_Q16:       cfg_gain       = data[pcm_pkg::GAIN_W-1:0];
            pcm_pkg::CFG_OFFSET_MA:      cfg_offset     = data[pcm_pkg::MA_W-1:0];
            pcm_pkg::CFG_ZERO_FLOOR_MA:  cfg_zero_floor = data[pcm_pkg::MA_W-1:0];
            pcm_pkg::CFG_LINE_VOLTS:     cfg_volts      = data[pcm_pkg::VOLTS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [pcm_pkg::CFG_DATA_W-1:0] win,
                             input logic [pcm_pkg::CFG_DATA_W-1:0] flr,
                             input logic [pcm_pkg::CFG_DATA_W-1:0] hits,
                             input logic [pcm_pkg::CFG_DATA_W-1:0] gain,
                             input logic [pcm_pkg::CFG_DATA_W-1:0] ofs,
                             input logic [pcm_pkg::CFG_DATA_W-1:0] zfl,
                             input logic [pcm_pkg::CFG_DATA_W-1:0] volts);
        write_reg(pcm_pkg::CFG_WINDOW_SAMPLES, win);
        write_reg(pcm_pkg::CFG_NOISE_FLOOR, flr);
        write_reg(pcm_pkg::CFG_MIN_HITS, hits);
        write_reg(pcm_pkg::CFG_GAIN_Q16, gain);
        write_reg(pcm_pkg::CFG_OFFSET_MA, ofs);
        write_reg(pcm_pkg::CFG_ZERO_FLOOR_MA, zfl);
        write_reg(pcm_pkg::CFG_LINE_VOLTS, volts);
    endtask

    task automatic pick_config();
        logic [pcm_pkg::CFG_DATA_W-1:0] win, flr, hits, gain, ofs, zfl, volts;
        case ($urandom_range(9))
            0:       win = 0;
            1:       win = 1;
            2:       win = pcm_pkg::CFG_DATA_W'($urandom_range(25, 60));
            default: win = pcm_pkg::CFG_DATA_W'($urandom_range(2, 16));
        endcase
        case ($urandom_range(5))
            0:       flr = 0;
            1:       flr = 4095;
            2:       flr = pcm_pkg::CFG_DATA_W'($urandom_range(4095));
            default: flr = pcm_pkg::CFG_DATA_W'($urandom_range(400));
        endcase
        case ($urandom_range(5))
            0:       hits = 0;
            1:       hits = 1023;
            default: hits = pcm_pkg::CFG_DATA_W'($urandom_range(32'(win)));
        endcase
        case ($urandom_range(5))
            0:       gain = 0;
            1:       gain = 24'hFFFFFF;
            2:       gain = pcm_pkg::CFG_DATA_W'($urandom);
            default: gain = pcm_pkg::CFG_DATA_W'($urandom_range(4000000));
        endcase
        case ($urandom_range(4))
            0:       ofs = 65535;
            1:       ofs = pcm_pkg::CFG_DATA_W'($urandom);
            default: ofs = pcm_pkg::CFG_DATA_W'($urandom_range(500));
        endcase
        case ($urandom_range(5))
            0:       zfl = 0;
            1:       zfl = 65535;
            default: zfl = pcm_pkg::CFG_DATA_W'($urandom_range(3000));
        endcase
        case ($urandom_range(4))
            0:       volts = 0;
            1:       volts = 511;
            default: volts = pcm_pkg::CFG_DATA_W'($urandom);
        endcase
        write_all(win, flr, hits, gain, ofs, zfl, volts);
        if ($urandom_range(2) == 0) write_reg(CFG_UNUSED, pcm_pkg::CFG_DATA_W'($urandom));
    endtask

    task automatic drain();
        while (sample_fifo.size() != 0 || in_valid || pending_readings.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) predict_reading(in_sample);
            if (!in_valid || !o_in_stall) begin
                if (sample_fifo.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    in_sample <= sample_fifo.pop_front();
                    in_valid  <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_reading got;
        t_reading want;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                got.current_ma  = o_current_ma;
                got.power_mw    = o_power_mw;
                got.signal_seen = o_signal_seen;
                if (pending_readings.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected reading: current %0d power %0d seen %0b",
                                 got.current_ma, got.power_mw, got.signal_seen);
                    mismatches++;
                end else begin
                    want = pending_readings.pop_front();
                    if (got.current_ma != want.current_ma || got.power_mw != want.power_mw ||
                        got.signal_seen != want.signal_seen) begin
                        if (mismatches < 10)
                            $display("reading mismatch: current %0d/%0d power %0d/%0d seen %0b/%0b",
                                     want.current_ma, got.current_ma, want.power_mw,
                                     got.power_mw, want.signal_seen, got.signal_seen);
                        mismatches++;
                    end
                end
            end
            if (hold_req && !hold_used) begin
                hold_used = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    initial begin
        int cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb_top NOT OK");
        $finish;
    end

    initial begin
        int p;
        load_defaults();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        repeat (70) sample_fifo.push_back(draw_sample());
        drain();

        write_all(0, 100, 0, 24'hFFFFFF, 65535, 0, 511);
        write_reg(CFG_UNUSED, 24'hFFFFFF);
        foreach (EDGE_SAMPLES[k]) sample_fifo.push_back(EDGE_SAMPLES[k]);
        drain();

        write_all(1, 0, 1023, 0, 0, 65535, 0);
        sample_fifo.push_back(12'd4095);
        sample_fifo.push_back(12'd0);
        drain();

        write_all(3, 4095, 2, 65536, 0, 10, 1);
        foreach (FLOOR_SAMPLES[k]) sample_fifo.push_back(FLOOR_SAMPLES[k]);
        drain();

        for (p = 0; p < 7; p++) begin
            pick_config();
            if (p == 0) begin
                write_reg(pcm_pkg::CFG_WINDOW_SAMPLES, 1);
                hold_req = 1'b1;
            end
            calm = (p == 3);
            repeat (100) sample_fifo.push_back(draw_sample());
            drain();
            calm = 1'b0;
            if (p == 4) begin
                write_all(1023, 0, 1022,
                          pcm_pkg::CFG_DATA_W'($urandom_range(4000000)),
                          pcm_pkg::CFG_DATA_W'($urandom_range(500)), 0,
                          pcm_pkg::CFG_DATA_W'($urandom));
                repeat (1023) sample_fifo.push_back(draw_sample());
                drain();
            end
        end

        if (mismatches == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
